### rtl/sorted_priority_queue_top_assert.svh
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define SPQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(label, expr, msg)
`define SPQ_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### rtl/spq_pkg.sv
// Package with the types, constants and key compare of the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] stamp;
        logic [15:0] id;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

    // True when entry a must be served strictly before entry b.
    function automatic logic goes_before(t_entry a, t_entry b);
        logic result;
        if (a.prio != b.prio) begin
            result = a.prio < b.prio;
        end else if (a.stamp != b.stamp) begin
            result = a.stamp < b.stamp;
        end else begin
            result = a.id < b.id;
        end
        return result;
    endfunction

endpackage

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: control, cell chain and result register.
// The result of a transaction is registered and appears in the cycle after it is accepted.
// Throughput: one transaction per cycle while the input is not stalled.
// The input stalls only while a result waits on a stalled output.
// Reset (synchronous, active low) clears the cell valid flags, the count and the
// result valid flag; entry payloads and result fields are not cleared.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_new_priority,
    input  logic [31:0] i_arrival_time,
    input  logic [15:0] i_entry_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_taken_valid,
    output logic [7:0]  o_taken_priority,
    output logic [31:0] o_taken_time,
    output logic [15:0] o_taken_id,
    output logic        o_head_valid,
    output logic [7:0]  o_head_priority,
    output logic [31:0] o_head_time,
    output logic [15:0] o_head_id,
    output logic [4:0]  o_occupancy,
    output logic        o_dropped
);
    import spq_pkg::*;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    t_cell_ctrl             w_ctrl;
    t_entry                 w_new;
    logic [QUEUE_DEPTH-1:0] w_take;
    logic [QUEUE_DEPTH-1:0] w_valid;
    t_entry                 w_entry      [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_prev_take;
    logic [QUEUE_DEPTH-1:0] w_prev_valid;
    t_entry                 w_prev_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_next_valid;
    t_entry                 w_next_entry [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_taken_valid;
    logic             n_taken_valid;
    t_entry           r_taken;
    t_entry           n_taken;
    logic             r_dropped;
    logic             n_dropped;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = r_count == CNT_W'(QUEUE_DEPTH);
    assign w_empty  = r_count == '0;

    assign w_new.prio  = i_new_priority;
    assign w_new.stamp = i_arrival_time;
    assign w_new.id    = i_entry_id;

    always_comb begin
        w_ctrl.insert = w_accept && (i_mode == MODE_INSERT) && !w_full;
        w_ctrl.remove = w_accept && (i_mode == MODE_REMOVE) && !w_empty;
    end

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (k == 0) begin
                w_prev_take[k]  = 1'b0;
                w_prev_valid[k] = 1'b1;
                w_prev_entry[k] = '0;
            end else begin
                w_prev_take[k]  = w_take[k-1];
                w_prev_valid[k] = w_valid[k-1];
                w_prev_entry[k] = w_entry[k-1];
            end
            if (k == QUEUE_DEPTH - 1) begin
                w_next_valid[k] = 1'b0;
                w_next_entry[k] = '0;
            end else begin
                w_next_valid[k] = w_valid[k+1];
                w_next_entry[k] = w_entry[k+1];
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_prev_take  (w_prev_take[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_prev_entry (w_prev_entry[g]),
            .i_next_valid (w_next_valid[g]),
            .i_next_entry (w_next_entry[g]),
            .o_take       (w_take[g]),
            .o_valid      (w_valid[g]),
            .o_entry      (w_entry[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid && i_stall;
        n_taken_valid = r_taken_valid;
        n_taken       = r_taken;
        n_dropped     = r_dropped;
        if (w_accept) begin
            n_out_valid   = 1'b1;
            n_taken_valid = w_ctrl.remove;
            n_taken       = w_ctrl.remove ? w_entry[0] : '0;
            n_dropped     = (i_mode == MODE_INSERT) && w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taken_valid <= n_taken_valid;
        r_taken       <= n_taken;
        r_dropped     <= n_dropped;
    end

    assign o_valid          = r_out_valid;
    assign o_taken_valid    = r_taken_valid;
    assign o_taken_priority = r_taken.prio;
    assign o_taken_time     = r_taken.stamp;
    assign o_taken_id       = r_taken.id;
    assign o_head_valid     = w_valid[0];
    assign o_head_priority  = w_valid[0] ? w_entry[0].prio  : '0;
    assign o_head_time      = w_valid[0] ? w_entry[0].stamp : '0;
    assign o_head_id        = w_valid[0] ? w_entry[0].id    : '0;
    assign o_occupancy      = 5'(r_count);
    assign o_dropped        = r_dropped;

    `SPQ_ASSERT_ALWAYS(a_count_matches, $countones(w_valid) == int'(r_count), "count mismatch")
    `SPQ_ASSERT_ALWAYS(a_valid_packed, (w_valid & (w_valid + 1'b1)) == '0, "valid gap")
    `SPQ_ASSERT_NEXT(a_hold_on_stall, o_stall, $stable(r_count) && $stable(w_valid), "state moved")
    `SPQ_ASSERT_ALWAYS(a_drop_when_full, !(r_out_valid && r_dropped) || w_full, "drop not full")

endmodule

### rtl/spq_cell.sv
// One compare-and-shift cell of the sorted priority queue chain.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry    i_new,
    input  logic               i_prev_take,
    input  logic               i_prev_valid,
    input  spq_pkg::t_entry    i_prev_entry,
    input  logic               i_next_valid,
    input  spq_pkg::t_entry    i_next_entry,
    output logic               o_take,
    output logic               o_valid,
    output spq_pkg::t_entry    o_entry
);
    import spq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_take;

    assign w_take = !r_valid || goes_before(i_new, r_entry);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctrl.insert && w_take) begin
            if (i_prev_take) begin
                n_valid = i_prev_valid;
                n_entry = i_prev_entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_new;
            end
        end else if (i_ctrl.remove) begin
            n_valid = i_next_valid;
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_take  = w_take;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the sorted priority queue, with a mirror of the queue contents.
module testbench;
    import spq_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1350;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int HOLDOFF_AFTER = 400;

    typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} t_phase;

    typedef struct packed {
        logic       taken_valid;
        t_entry     taken;
        logic       head_valid;
        t_entry     head;
        logic [4:0] occupancy;
        logic       dropped;
    } t_outcome;

    class queue_mirror;
        t_entry   held[QUEUE_DEPTH];
        int       held_n = 0;
        t_outcome pending_outcomes[$];
        int       errors = 0;

        function void note_request(logic [1:0] mode, t_entry e);
            t_outcome o;
            int pos;
            o = '0;
            case (mode)
                MODE_INSERT: begin
                    if (held_n >= QUEUE_DEPTH) begin
                        o.dropped = 1'b1;
                    end else begin
                        // An entry with an equal key goes behind those already held.
                        pos = 0;
                        while (pos < held_n && !({e.prio, e.stamp, e.id} <
                               {held[pos].prio, held[pos].stamp, held[pos].id})) begin
                            pos++;
                        end
                        for (int k = held_n; k > pos; k--) begin
                            held[k] = held[k - 1];
                        end
                        held[pos] = e;
                        held_n++;
                    end
                end
                MODE_REMOVE: begin
                    if (held_n > 0) begin
                        o.taken_valid = 1'b1;
                        o.taken = held[0];
                        for (int k = 0; k + 1 < held_n; k++) begin
                            held[k] = held[k + 1];
                        end
                        held_n--;
                    end
                end
                default: begin
                end
            endcase
            if (held_n > 0) begin
                o.head_valid = 1'b1;
                o.head = held[0];
            end
            o.occupancy = 5'(held_n);
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no transaction outstanding", $time);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("taken_valid", 32'(want.taken_valid), 32'(got.taken_valid));
            compare_field("taken_priority", 32'(want.taken.prio), 32'(got.taken.prio));
            compare_field("taken_time", want.taken.stamp, got.taken.stamp);
            compare_field("taken_id", 32'(want.taken.id), 32'(got.taken.id));
            compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
            compare_field("head_priority", 32'(want.head.prio), 32'(got.head.prio));
            compare_field("head_time", want.head.stamp, got.head.stamp);
            compare_field("head_id", 32'(want.head.id), 32'(got.head.id));
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = MODE_PEEK;
    logic [7:0]  i_new_priority = '0;
    logic [31:0] i_arrival_time = '0;
    logic [15:0] i_entry_id = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_taken_valid;
    logic [7:0]  o_taken_priority;
    logic [31:0] o_taken_time;
    logic [15:0] o_taken_id;
    logic        o_head_valid;
    logic [7:0]  o_head_priority;
    logic [31:0] o_head_time;
    logic [15:0] o_head_id;
    logic [4:0]  o_occupancy;
    logic        o_dropped;

    queue_mirror mirror = new();
    int inputs_accepted = 0;
    int burst_left = 0;

    sorted_priority_queue_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_new_priority   (i_new_priority),
        .i_arrival_time   (i_arrival_time),
        .i_entry_id       (i_entry_id),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_taken_valid    (o_taken_valid),
        .o_taken_priority (o_taken_priority),
        .o_taken_time     (o_taken_time),
        .o_taken_id       (o_taken_id),
        .o_head_valid     (o_head_valid),
        .o_head_priority  (o_head_priority),
        .o_head_time      (o_head_time),
        .o_head_id        (o_head_id),
        .o_occupancy      (o_occupancy),
        .o_dropped        (o_dropped)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_entry pick_entry();
        t_entry e;
        case ($urandom_range(0, 3))
            0: e = t_entry'{8'($urandom), $urandom, 16'($urandom)};
            1: e = t_entry'{8'($urandom_range(0, 3)), 32'($urandom_range(0, 3)),
                            16'($urandom_range(0, 3))};
            2: e = t_entry'{$urandom_range(0, 1) ? 8'hFF : 8'h00,
                            $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0,
                            $urandom_range(0, 1) ? 16'hFFFF : 16'h0};
            default: e = t_entry'{8'($urandom_range(0, 3)), $urandom,
                                  16'($urandom_range(0, 3))};
        endcase
        return e;
    endfunction

    function automatic logic [1:0] pick_mode(t_phase phase);
        int r;
        int ins_limit;
        int rem_limit;
        r = $urandom_range(0, 99);
        ins_limit = (phase == PHASE_FILL) ? 70 : (phase == PHASE_DRAIN) ? 15 : 45;
        rem_limit = (phase == PHASE_FILL) ? 85 : (phase == PHASE_DRAIN) ? 80 : 85;
        if (r < ins_limit) return MODE_INSERT;
        if (r < rem_limit) return MODE_REMOVE;
        if (r < 95) return MODE_PEEK;
        return MODE_SPARE;
    endfunction

    task automatic offer(logic [1:0] mode, t_entry e);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_mode <= mode;
        i_new_priority <= e.prio;
        i_arrival_time <= e.stamp;
        i_entry_id <= e.id;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.note_request(mode, e);
        inputs_accepted++;
    endtask

    initial begin
        t_phase phase;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(MODE_PEEK, pick_entry());
        offer(MODE_REMOVE, pick_entry());
        offer(MODE_SPARE, pick_entry());
        offer(MODE_INSERT, t_entry'{8'h80, 32'd1000, 16'd5});
        offer(MODE_INSERT, t_entry'{8'h80, 32'd1000, 16'd5});
        offer(MODE_INSERT, t_entry'{8'h80, 32'd1000, 16'd4});
        offer(MODE_INSERT, t_entry'{8'h80, 32'd999, 16'hFFFF});
        offer(MODE_INSERT, t_entry'{8'h7F, 32'hFFFF_FFFF, 16'hFFFF});
        offer(MODE_INSERT, t_entry'{8'hFF, 32'hFFFF_FFFF, 16'hFFFF});
        offer(MODE_INSERT, t_entry'{8'h00, 32'h0, 16'h0});
        offer(MODE_PEEK, t_entry'{8'hFF, 32'hFFFF_FFFF, 16'hFFFF});
        offer(MODE_SPARE, t_entry'{8'h00, 32'h0, 16'h0});
        repeat (8) offer(MODE_REMOVE, pick_entry());

        while (inputs_accepted < ITEM_TARGET) begin
            phase = t_phase'($urandom_range(0, 2));
            len = $urandom_range(10, 60);
            repeat (len) offer(pick_mode(phase), pick_entry());
        end

        i_valid <= 1'b0;
        while (mirror.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("sorted_priority_queue_top: match");
        end else begin
            $display("sorted_priority_queue_top: mismatch");
        end
        $finish;
    end

    initial begin
        t_outcome got;
        int hold_left;
        int run_left;
        bit holdoff_done;
        bit stalling;
        hold_left = 0;
        run_left = 0;
        holdoff_done = 1'b0;
        stalling = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.taken_valid = o_taken_valid;
                got.taken = t_entry'{o_taken_priority, o_taken_time, o_taken_id};
                got.head_valid = o_head_valid;
                got.head = t_entry'{o_head_priority, o_head_time, o_head_id};
                got.occupancy = o_occupancy;
                got.dropped = o_dropped;
                mirror.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!holdoff_done && inputs_accepted >= HOLDOFF_AFTER) begin
                // Hold the output long enough that the block must stall its input.
                holdoff_done = 1'b1;
                hold_left = HOLDOFF_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling && ($urandom_range(0, 3) != 0);
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 40);
                end
                run_left--;
                i_stall <= stalling;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sorted_priority_queue_top: mismatch");
                $finish;
            end
        end
    end

endmodule

### sorted_priority_queue_top.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sv/testbench.sv
